>>> rtl/lkv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // Word index of the capacity register (byte address 0).
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // Request handed to the entry store.
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } req_t;

  // Lookup response of a get.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } rsp_t;

endpackage : lkv_pkg
`default_nettype wire

>>> rtl/lkv_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_cfg_regs
// APB register slice holding the capacity register.
// ----------------------------------------------------------------------------
module lkv_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [lkv_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [lkv_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [lkv_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready,
  output logic      [lkv_pkg::CAP_W-1:0]       capacity
);

  logic [lkv_pkg::CAP_W-1:0] capacity_r;
  logic [lkv_pkg::CAP_W-1:0] capacity_nxt;
  logic                      sel_cap;
  logic                      wr_en;

  assign cfg_pready = 1'b1;
  assign sel_cap    = (cfg_paddr[2] == lkv_pkg::REG_CAPACITY);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    capacity_nxt = capacity_r;
    if (wr_en && sel_cap) begin
      capacity_nxt = cfg_pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lkv_pkg::CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_cap) begin
      cfg_prdata = lkv_pkg::CFG_DATA_W'(capacity_r);
    end
  end

  assign capacity = capacity_r;

endmodule : lkv_cfg_regs
`default_nettype wire

>>> rtl/lkv_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_store
// Entry array: parallel key match, age ranks, fill and eviction.
// ----------------------------------------------------------------------------
module lkv_store #(
  parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [lkv_pkg::CAP_W-1:0] capacity,
  input  wire lkv_pkg::req_t             req,
  output lkv_pkg::rsp_t                  rsp
);

  localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

  logic [lkv_pkg::DATA_W-1:0] key_r   [ENTRIES];
  logic [lkv_pkg::DATA_W-1:0] value_r [ENTRIES];
  logic [RANK_W-1:0]          rank_r  [ENTRIES];
  logic [RANK_W-1:0]          rank_nxt[ENTRIES];
  logic [ENTRIES-1:0]         valid_r;
  logic [ENTRIES-1:0]         valid_nxt;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;

  logic [ENTRIES-1:0]         hit_vec;
  logic [ENTRIES-1:0]         free_oh;
  logic [ENTRIES-1:0]         oldest_oh;
  logic [ENTRIES-1:0]         tgt_oh;
  logic [ENTRIES-1:0]         wr_vec;
  logic                       hit;
  logic [RANK_W-1:0]          hit_rank;
  logic [RANK_W-1:0]          oldest_rank;
  logic [RANK_W-1:0]          thr;
  logic [lkv_pkg::DATA_W-1:0] hit_value;
  logic [CMP_W-1:0]           cap_eff;
  logic                       full;
  logic                       do_touch;
  logic                       do_insert;
  logic                       do_evict;

  // Effective capacity: zero reads as one, large values clamp to the array size.
  always_comb begin
    cap_eff = CMP_W'(capacity);
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  assign full        = (CMP_W'(count_r) >= cap_eff);
  // Valid ranks are always 0..count-1, so the LRU entry holds count-1.
  assign oldest_rank = RANK_W'(count_r - CNT_W'(1));
  // Lowest clear bit of the valid vector.
  assign free_oh     = ~valid_r & (valid_r + ENTRIES'(1));

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = valid_r[i] && (key_r[i] == req.key);
      oldest_oh[i] = valid_r[i] && (rank_r[i] == oldest_rank);
      hit_rank     = hit_rank  | (hit_vec[i] ? rank_r[i] : '0);
      hit_value    = hit_value | (hit_vec[i] ? value_r[i] : '0);
    end
  end

  assign hit       = |hit_vec;
  assign do_touch  = req.valid && hit;
  assign do_insert = req.valid && !hit && (req.op == lkv_pkg::OP_PUT) && !full;
  assign do_evict  = req.valid && !hit && (req.op == lkv_pkg::OP_PUT) && full;

  always_comb begin
    tgt_oh = '0;
    thr    = hit_rank;
    if (do_touch) begin
      tgt_oh = hit_vec;
    end else if (do_insert) begin
      tgt_oh = free_oh;
    end else if (do_evict) begin
      tgt_oh = oldest_oh;
      thr    = oldest_rank;
    end
  end

  // Key and value are written on every put to the chosen slot.
  assign wr_vec = (req.valid && (req.op == lkv_pkg::OP_PUT)) ? tgt_oh : '0;

  always_comb begin
    valid_nxt = valid_r | tgt_oh;
    count_nxt = do_insert ? (count_r + CNT_W'(1)) : count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (tgt_oh[i]) begin
        rank_nxt[i] = '0;
      end else if (valid_r[i] && (do_insert || ((do_touch || do_evict) && (rank_r[i] < thr))))
      begin
        rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_vec[i]) begin
        key_r[i]   <= req.key;
        value_r[i] <= req.value;
      end
    end
  end

  always_comb begin
    rsp.valid      = req.valid && (req.op == lkv_pkg::OP_GET);
    rsp.hit        = hit;
    rsp.read_value = hit ? hit_value : lkv_pkg::MISS_VALUE;
  end

  // Keys among valid entries stay distinct.
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one entry matched the key");

  // Fill count tracks the valid bits.
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("fill count out of step with valid bits");

  // A fill of a free slot grows the count by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the fill count");

  // An eviction always finds exactly one LRU entry.
  a_evict_one: assert property (@(posedge clk) disable iff (!rst_n)
    do_evict |-> $onehot(oldest_oh))
    else $error("eviction without a unique LRU entry");

endmodule : lkv_store
`default_nettype wire

>>> rtl/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Pipeline: a get request passes the input register, then the result register,
//   before its result shows on out_*; a stalled result holds it in the input register.
// Throughput: one request per cycle, gets and puts in any mix; a put never waits
//   on the result side, a stalled result holds a waiting get and the input with it.
// Reset (rst_n, synchronous, active low): all entries invalid, fill count zero,
//   capacity 16, pipeline empty. No clearing pass; the cache is usable at once.
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [63:0]                     in_tdata,   // [31:0] key, [63:32] value
  input  wire logic                            in_tuser,   // [0] operation (0 get, 1 put)
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [31:0]                     out_tdata,  // [31:0] read_value
  output logic                                 out_tuser,  // [0] hit
  // configuration
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [lkv_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [lkv_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [lkv_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);

  // Input register stage
  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  lkv_pkg::op_t               s1_op_r;
  logic [lkv_pkg::DATA_W-1:0] s1_key_r;
  logic [lkv_pkg::DATA_W-1:0] s1_value_r;

  // Result register
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       out_hit_r;
  logic [lkv_pkg::DATA_W-1:0] out_value_r;

  logic                       process_ok;
  logic                       in_fire;
  logic [lkv_pkg::CAP_W-1:0]  capacity;
  lkv_pkg::req_t              req;
  lkv_pkg::rsp_t              rsp;

  lkv_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .capacity    (capacity)
  );

  // A put never needs the result slot; a get needs it empty or draining.
  assign process_ok = (s1_op_r == lkv_pkg::OP_PUT) || !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || process_ok;
  assign in_fire    = in_tvalid && in_tready;

  always_comb begin
    req.valid = s1_valid_r && process_ok;
    req.op    = s1_op_r;
    req.key   = s1_key_r;
    req.value = s1_value_r;
  end

  lkv_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity),
    .req      (req),
    .rsp      (rsp)
  );

  assign s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= lkv_pkg::op_t'(in_tuser);
      s1_key_r   <= in_tdata[31:0];
      s1_value_r <= in_tdata[63:32];
    end
    if (rsp.valid) begin
      out_hit_r   <= rsp.hit;
      out_value_r <= rsp.read_value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_value_r;

endmodule : lru_key_value_cache
`default_nettype wire
